@@ hdl/bmp565_pkg.sv @@
`timescale 1ns / 1ps

package bmp565_pkg;

	// Pixel format codes; code 3 is handled as 24-bit
	typedef enum logic [1:0] {
		FMT_PAL8  = 2'd0,
		FMT_RGB16 = 2'd1,
		FMT_BGR24 = 2'd2
	} fmt_t;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_PIXEL_FORMAT   = 2'd0;
	localparam logic [1:0] REG_ROW_WIDTH      = 2'd1;
	localparam logic [1:0] REG_FIVE_BIT_GREEN = 2'd2;

	// Item kinds
	localparam logic ACT_PIXEL_BYTE    = 1'b0;
	localparam logic ACT_PALETTE_WRITE = 1'b1;

	localparam int CFG_DATA_W = 13;

	// Settings seen by the pixel path
	typedef struct packed {
		fmt_t fmt;
		logic green555;
	} cfg_t;

	// Bytes per pixel for a format code
	function automatic logic [1:0] bytes_per_pixel(input fmt_t fmt);
		logic [1:0] b;
		case (fmt)
			FMT_PAL8:  b = 2'd1;
			FMT_RGB16: b = 2'd2;
			default:   b = 2'd3;
		endcase
		return b;
	endfunction

	// Truncate 24-bit RGB to RGB565
	function automatic logic [15:0] to565(input logic [23:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

endpackage

@@ hdl/bmp565_ram.sv @@
`timescale 1ns / 1ps

module bmp565_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/bmp565_cfg.sv @@
`timescale 1ns / 1ps

module bmp565_cfg #(
	parameter int MAX_ROW_PIXELS = 4096,
	parameter int CNT_W          = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [bmp565_pkg::CFG_DATA_W-1:0] cfg_data,
	output bmp565_pkg::cfg_t             cfg,
	output logic [CNT_W-1:0]             row_data
);

	import bmp565_pkg::*;

	localparam int WID_W     = $clog2(MAX_ROW_PIXELS + 1);
	// Reset width of 240 pixels, clamped like a written width
	localparam int RST_WIDTH = (MAX_ROW_PIXELS < 240) ? MAX_ROW_PIXELS : 240;

	fmt_t              fmt_q;
	logic              green_q;
	logic [WID_W-1:0]  width_q;
	logic [CNT_W-1:0]  row_data_q;
	logic [WID_W-1:0]  width_new;
	logic              wr;

	// Row data size in bytes for a pixel size and a clamped width
	function automatic logic [CNT_W-1:0] row_bytes(input logic [1:0] bpp,
			input logic [WID_W-1:0] w);
		logic [CNT_W-1:0] r;
		case (bpp)
			2'd1:    r = CNT_W'(w);
			2'd2:    r = CNT_W'(w) << 1;
			default: r = CNT_W'(w) + (CNT_W'(w) << 1);
		endcase
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	// Clamp the written width into 1..MAX_ROW_PIXELS
	always_comb begin
		if (cfg_data == '0) begin
			width_new = WID_W'(1);
		end else if (32'(cfg_data) > MAX_ROW_PIXELS) begin
			width_new = WID_W'(MAX_ROW_PIXELS);
		end else begin
			width_new = WID_W'(cfg_data);
		end
	end

	// Hold registers and refresh the row size on each format or width write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_BGR24;
			green_q    <= 1'b0;
			width_q    <= WID_W'(RST_WIDTH);
			row_data_q <= CNT_W'(3 * RST_WIDTH);
		end else if (wr) begin
			case (cfg_index)
				REG_PIXEL_FORMAT: begin
					fmt_q      <= fmt_t'(cfg_data[1:0]);
					row_data_q <= row_bytes(bytes_per_pixel(fmt_t'(cfg_data[1:0])), width_q);
				end
				REG_ROW_WIDTH: begin
					width_q    <= width_new;
					row_data_q <= row_bytes(bytes_per_pixel(fmt_q), width_new);
				end
				REG_FIVE_BIT_GREEN: begin
					green_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.fmt      = fmt_q;
	assign cfg.green555 = green_q;
	assign row_data     = row_data_q;

endmodule

@@ hdl/bmp_pixel_to_rgb565_converter.sv @@
`timescale 1ns / 1ps
// A result item passes the stage 1 and stage 2 registers after its last byte.
// Throughput: one item per cycle while in_stall is low; the palette RAM takes
// one read and one write per cycle; a palette write reaches the very next item.
// Reset clears byte phase, row count, padding count and the pipeline; the palette
// RAM is not cleared and holds nothing usable until written.
module bmp_pixel_to_rgb565_converter #(
	parameter int PALETTE_DEPTH  = 256,
	parameter int MAX_ROW_PIXELS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [bmp565_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [7:0]                        data_byte,
	input  logic [7:0]                        palette_index,
	input  logic [23:0]                       palette_color,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       pixel_rgb565,
	output logic                              row_end
);

	import bmp565_pkg::*;

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);
	localparam int CNT_W  = $clog2(3 * MAX_ROW_PIXELS + 3);

	cfg_t              cfg;
	logic [CNT_W-1:0]  row_data;
	logic [1:0]        pad;
	logic [1:0]        bpp;

	logic [15:0]       held_q;
	logic [1:0]        phase_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        padleft_q;

	logic              accept;
	logic              adv_s1;
	logic              adv_s2;
	logic              is_pixel;
	logic              dropping;
	logic              gathering;
	logic              emit;
	logic [CNT_W-1:0]  count_next;
	logic              row_done;
	logic [15:0]       pix16;
	logic [15:0]       pix_c;
	logic              pal_we;
	logic [15:0]       pal_rdata;

	logic              v_s1;
	logic              pal_s1;
	logic              oob_s1;
	logic [15:0]       pix_s1;
	logic              end_s1;
	logic              v_s2;
	logic [15:0]       pix_s2;
	logic              end_s2;

	bmp565_cfg #(
		.MAX_ROW_PIXELS(MAX_ROW_PIXELS),
		.CNT_W(CNT_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.row_data(row_data)
	);

	// Advance the two stages; stall input only when both are full and blocked
	assign adv_s2   = !v_s2 || !out_stall;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign accept   = in_valid && !in_stall;

	// Decode what the accepted byte does
	assign bpp        = bytes_per_pixel(cfg.fmt);
	assign pad        = 2'(2'd0 - row_data[1:0]);
	assign is_pixel   = (action == ACT_PIXEL_BYTE);
	assign dropping   = is_pixel && (padleft_q != 2'd0);
	assign gathering  = is_pixel && !dropping && ((3'(phase_q) + 3'd1) < 3'(bpp));
	assign emit       = is_pixel && !dropping && !gathering;
	assign count_next = count_q + CNT_W'(bpp);
	assign row_done   = (count_next >= row_data);

	// Build the direct-color pixel
	assign pix16 = {data_byte, held_q[7:0]};
	always_comb begin
		case (cfg.fmt)
			FMT_RGB16: begin
				if (cfg.green555) begin
					pix_c = {pix16[14:10], pix16[9:5], 1'b0, pix16[4:0]};
				end else begin
					pix_c = pix16;
				end
			end
			default: pix_c = to565({data_byte, held_q});
		endcase
	end

	// Palette RAM: write on in-range palette items, read on every accepted item
	assign pal_we = accept && (action == ACT_PALETTE_WRITE) && (9'(palette_index) < PALETTE_DEPTH);

	bmp565_ram #(
		.WIDTH(16),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk(clk),
		.we(pal_we),
		.waddr(palette_index[PAL_AW-1:0]),
		.wdata(to565(palette_color)),
		.re(accept),
		.raddr(data_byte[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	// Update byte phase, row count and padding count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			count_q   <= '0;
			padleft_q <= 2'd0;
		end else if (accept) begin
			if (dropping) begin
				padleft_q <= padleft_q - 2'd1;
			end else if (gathering) begin
				phase_q <= phase_q + 2'd1;
			end else if (emit) begin
				phase_q <= 2'd0;
				if (row_done) begin
					count_q   <= '0;
					padleft_q <= pad;
				end else begin
					count_q <= count_next;
				end
			end
		end
	end

	// Hold partial pixel bytes
	always_ff @(posedge clk) begin
		if (accept && gathering) begin
			if (phase_q == 2'd0) begin
				held_q[7:0] <= data_byte;
			end else begin
				held_q[15:8] <= data_byte;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= accept && emit;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pal_s1 <= (cfg.fmt == FMT_PAL8);
			oob_s1 <= (9'(data_byte) >= PALETTE_DEPTH);
			pix_s1 <= pix_c;
			end_s1 <= row_done;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	// Stage 2 payload: pick palette data or direct pixel
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			if (pal_s1) begin
				pix_s2 <= oob_s1 ? 16'd0 : pal_rdata;
			end else begin
				pix_s2 <= pix_s1;
			end
			end_s2 <= end_s1;
		end
	end

	assign out_valid    = v_s2;
	assign pixel_rgb565 = pix_s2;
	assign row_end      = end_s2;

	// Padding starts only on a pixel boundary
	assert property (@(posedge clk) disable iff (!arst_n)
		(padleft_q != 2'd0) |-> (phase_q == 2'd0))
		else $error("padding pending mid-pixel");

	// A dropped padding byte counts down by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && dropping) |=> (padleft_q == $past(padleft_q) - 2'd1))
		else $error("padding count did not step");

	// Input stalls only when both stages are full and output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_stall))
		else $error("input stalled with room in pipeline");

	// Byte phase never reaches a full 24-bit pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("byte phase overflow");

endmodule
